// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge of clk, off while in reset
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// implication checked in the cycle after the condition
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/ple_pkg.sv
// types and codes shared by the positional list engine
package ple_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_INS_AFTER  = 3'd2,
        ACT_LIST_ALL   = 3'd3,
        ACT_POP_FRONT  = 3'd4,
        ACT_POP_BACK   = 3'd5,
        ACT_REMOVE_AT  = 3'd6,
        ACT_FIND       = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    localparam int unsigned ELEM_BITS = 32;
    localparam int unsigned POS_BITS  = 5;

    typedef struct packed {
        action_t                      action;
        logic signed [ELEM_BITS-1:0]  new_value;
        logic        [POS_BITS-1:0]   where;
    } in_t;

    typedef struct packed {
        status_t                      status;
        logic signed [ELEM_BITS-1:0]  element;
        logic        [POS_BITS-1:0]   index;
        logic        [POS_BITS-1:0]   length;
        logic                         last_of_run;
    } out_t;

endpackage

// File: rtl/ple_ram.sv
// generic single write port ram with registered read
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/positional_list_engine.sv
// positional list engine: ordered list with positional insert, remove, find and listing
//
//   channel  | flow | handshake           | payload
//   in       | in   | in_valid / in_ready   | ple_pkg::in_t
//   out      | out  | out_valid / out_ready | ple_pkg::out_t
//
// one transaction at a time; in_ready is high only while the sequencer is idle
// entries behind pos shift one a cycle through the ram port; listing reads each element
// in turn and loads it as its own result, the last one flagged last_of_run
// reset clears the length and control state; list contents stay undefined until written
// a stalled output holds the sequencer only where the next result is ready to load
`include "assert_macros.svh"

module positional_list_engine #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ple_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ple_pkg::out_t out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > ple_pkg::POS_BITS) ? LW : ple_pkg::POS_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_MOVE,
        S_WRITE_NEW,
        S_REM_RD,
        S_REM_CAP,
        S_LIST_RD,
        S_LIST_WAIT,
        S_FIND,
        S_RESP
    } state_t;

    state_t                         state_reg, state_next;
    ple_pkg::action_t               act_reg, act_next;
    logic [VALUE_BITS-1:0]          val_reg, val_next;
    logic [ple_pkg::POS_BITS-1:0]   where_reg, where_next;
    logic [LW-1:0]                  len_reg, len_next;
    logic [LW-1:0]                  ptr_reg, ptr_next;
    logic [LW-1:0]                  cnt_reg, cnt_next;
    logic [LW-1:0]                  slot_reg, slot_next;
    logic [LW-1:0]                  idx_reg, idx_next;
    logic [LW-1:0]                  pend_dst_reg, pend_dst_next;
    logic                           pend_reg, pend_next;
    logic                           dir_up_reg, dir_up_next;
    ple_pkg::status_t               rs_status_reg, rs_status_next;
    logic [ple_pkg::ELEM_BITS-1:0]  rs_elem_reg, rs_elem_next;
    logic [ple_pkg::POS_BITS-1:0]   rs_index_reg, rs_index_next;
    ple_pkg::out_t                  out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [VALUE_BITS-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [VALUE_BITS-1:0] ram_rd_data;

    logic          out_free;
    logic          issue;
    logic [CW-1:0] where_w;
    logic [CW-1:0] len_w;
    logic          is_full;
    logic          is_empty;
    logic [LW-1:0] ins_slot;
    logic [LW-1:0] rem_slot;

    ple_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign where_w  = CW'(where_reg);
    assign len_w    = CW'(len_reg);
    assign is_full  = (len_reg >= LW'(DEPTH));
    assign is_empty = (len_reg == '0);

    always_comb
    begin
        ins_slot = '0;
        rem_slot = '0;
        case (act_reg)
            ple_pkg::ACT_PUSH_BACK: ins_slot = len_reg;
            ple_pkg::ACT_INS_AFTER: ins_slot = (where_reg == '0) ? LW'(1) : LW'(where_reg);
            default:                ins_slot = '0;
        endcase
        case (act_reg)
            ple_pkg::ACT_POP_BACK:  rem_slot = len_reg - LW'(1);
            ple_pkg::ACT_REMOVE_AT: rem_slot = LW'(where_reg) - LW'(1);
            default:                rem_slot = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        where_next     = where_reg;
        len_next       = len_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        pend_dst_next  = pend_dst_reg;
        pend_next      = 1'b0;
        dir_up_next    = dir_up_reg;
        rs_status_next = rs_status_reg;
        rs_elem_next   = rs_elem_reg;
        rs_index_next  = rs_index_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        ram_wr_en   = 1'b0;
        ram_wr_addr = pend_dst_reg[AW-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ptr_reg[AW-1:0];
        issue       = (cnt_reg != '0);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = in_data.action;
                    val_next   = VALUE_BITS'($unsigned(in_data.new_value));
                    where_next = in_data.where;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                rs_status_next = ple_pkg::ST_OK;
                rs_elem_next   = '0;
                rs_index_next  = '0;
                ptr_next       = '0;
                idx_next       = '0;
                unique case (act_reg) inside
                    ple_pkg::ACT_PUSH_FRONT, ple_pkg::ACT_PUSH_BACK, ple_pkg::ACT_INS_AFTER:
                    begin
                        if (act_reg == ple_pkg::ACT_INS_AFTER && is_empty)
                        begin
                            rs_status_next = ple_pkg::ST_EMPTY;
                            state_next     = S_RESP;
                        end
                        else if (act_reg == ple_pkg::ACT_INS_AFTER && where_w > len_w)
                        begin
                            rs_status_next = ple_pkg::ST_BADPOS;
                            state_next     = S_RESP;
                        end
                        else if (is_full)
                        begin
                            rs_status_next = ple_pkg::ST_FULL;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            slot_next   = ins_slot;
                            cnt_next    = len_reg - ins_slot;
                            ptr_next    = len_reg - LW'(1);
                            dir_up_next = 1'b1;
                            state_next  = S_MOVE;
                        end
                    end
                    ple_pkg::ACT_LIST_ALL:
                    begin
                        if (is_empty)
                        begin
                            rs_status_next = ple_pkg::ST_EMPTY;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            state_next = S_LIST_RD;
                        end
                    end
                    ple_pkg::ACT_POP_FRONT, ple_pkg::ACT_POP_BACK, ple_pkg::ACT_REMOVE_AT:
                    begin
                        if (is_empty)
                        begin
                            rs_status_next = ple_pkg::ST_EMPTY;
                            state_next     = S_RESP;
                        end
                        else if (act_reg == ple_pkg::ACT_REMOVE_AT &&
                                 (where_reg == '0 || where_w > len_w))
                        begin
                            rs_status_next = ple_pkg::ST_BADPOS;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            slot_next  = rem_slot;
                            state_next = S_REM_RD;
                        end
                    end
                    ple_pkg::ACT_FIND:
                    begin
                        if (is_empty)
                        begin
                            rs_status_next = ple_pkg::ST_EMPTY;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            state_next = S_FIND;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_MOVE:
            begin
                // read one entry a cycle, write it one place over in the cycle after
                ram_wr_en = pend_reg;
                if (issue)
                begin
                    ram_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_dst_next = dir_up_reg ? ptr_reg + LW'(1) : ptr_reg - LW'(1);
                    ptr_next      = dir_up_reg ? ptr_reg - LW'(1) : ptr_reg + LW'(1);
                    cnt_next      = cnt_reg - LW'(1);
                end
                else if (!pend_reg)
                begin
                    if (dir_up_reg)
                    begin
                        state_next = S_WRITE_NEW;
                    end
                    else
                    begin
                        len_next   = len_reg - LW'(1);
                        state_next = S_RESP;
                    end
                end
            end

            S_WRITE_NEW:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = slot_reg[AW-1:0];
                ram_wr_data = val_reg;
                len_next    = len_reg + LW'(1);
                state_next  = S_RESP;
            end

            S_REM_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = slot_reg[AW-1:0];
                state_next  = S_REM_CAP;
            end

            S_REM_CAP:
            begin
                rs_elem_next = ple_pkg::ELEM_BITS'(ram_rd_data);
                ptr_next     = slot_reg + LW'(1);
                cnt_next     = len_reg - LW'(1) - slot_reg;
                dir_up_next  = 1'b0;
                state_next   = S_MOVE;
            end

            S_LIST_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_LIST_WAIT;
            end

            S_LIST_WAIT:
            begin
                if (out_free)
                begin
                    out_next.status      = ple_pkg::ST_OK;
                    out_next.element     = ple_pkg::ELEM_BITS'(ram_rd_data);
                    out_next.index       = ple_pkg::POS_BITS'(ptr_reg + LW'(1));
                    out_next.length      = ple_pkg::POS_BITS'(len_reg);
                    out_next.last_of_run = ((ptr_reg + LW'(1)) == len_reg);
                    out_valid_next       = 1'b1;
                    ptr_next             = ptr_reg + LW'(1);
                    state_next           = ((ptr_reg + LW'(1)) == len_reg) ? S_IDLE : S_LIST_RD;
                end
            end

            S_FIND:
            begin
                issue = (ptr_reg < len_reg);
                if (pend_reg && ram_rd_data == val_reg)
                begin
                    rs_status_next = ple_pkg::ST_OK;
                    rs_elem_next   = ple_pkg::ELEM_BITS'(ram_rd_data);
                    rs_index_next  = ple_pkg::POS_BITS'(idx_reg + LW'(1));
                    state_next     = S_RESP;
                end
                else if (!issue)
                begin
                    rs_status_next = ple_pkg::ST_NOTFOUND;
                    state_next     = S_RESP;
                end
                else
                begin
                    ram_rd_en = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = ptr_reg;
                    ptr_next  = ptr_reg + LW'(1);
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_next.status      = rs_status_reg;
                    out_next.element     = rs_elem_reg;
                    out_next.index       = rs_index_reg;
                    out_next.length      = ple_pkg::POS_BITS'(len_reg);
                    out_next.last_of_run = 1'b1;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ple_pkg::ACT_PUSH_FRONT;
            val_reg       <= '0;
            where_reg     <= '0;
            len_reg       <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            pend_dst_reg  <= '0;
            pend_reg      <= 1'b0;
            dir_up_reg    <= 1'b0;
            rs_status_reg <= ple_pkg::ST_OK;
            rs_elem_reg   <= '0;
            rs_index_reg  <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            val_reg       <= val_next;
            where_reg     <= where_next;
            len_reg       <= len_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            slot_reg      <= slot_next;
            idx_reg       <= idx_next;
            pend_dst_reg  <= pend_dst_next;
            pend_reg      <= pend_next;
            dir_up_reg    <= dir_up_next;
            rs_status_reg <= rs_status_next;
            rs_elem_reg   <= rs_elem_next;
            rs_index_reg  <= rs_index_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_IMPLY(a_len_bound, 1'b1, len_reg <= LW'(DEPTH), "list length above depth")
    `ASSERT_IMPLY(a_idle_no_pend, state_reg == S_IDLE, !pend_reg && !ram_wr_en,
        "ram traffic while idle")
    `ASSERT_NEXT(a_len_hold, state_reg == S_IDLE, $stable(len_reg),
        "length changed on accepting a transaction")
    `ASSERT_IMPLY(a_index_ok, out_valid_reg && out_reg.index != '0,
        out_reg.status == ple_pkg::ST_OK, "index reported on a failed transaction")

endmodule
